/* hw/rtl/ptl_pkg.sv */
// Shared types and constants of the packed trie lookup unit.
`default_nettype none

package ptl_pkg;

    // Field widths of the item and result beats, the trie length and the scan arithmetic
    localparam int MODE_W   = 2;
    localparam int POS_W    = 14;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 15;
    localparam int COUNT_W  = 12;
    localparam int SUM_W    = 16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REWIND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd2;

    // Digit characters start at ASCII zero
    localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;

    // Read address selects
    localparam logic [2:0] RD_SCAN   = 3'd0;
    localparam logic [2:0] RD_SCAN1  = 3'd1;
    localparam logic [2:0] RD_CHILD  = 3'd2;
    localparam logic [2:0] RD_CHILD1 = 3'd3;
    localparam logic [2:0] RD_RESULT = 3'd4;

    typedef struct packed {
        logic       load_item;
        logic       mem_write;
        logic       rewind;
        logic       start_scan;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       load_hi;
        logic       load_total;
        logic       take_child;
        logic       advance;
        logic       set_fail;
        logic       load_out;
    } ptl_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              failed;
        logic              total_zero;
        logic              child_oob;
        logic              digit_hit;
        logic              scan_end;
        logic              out_free;
    } ptl_status_t;

endpackage

`default_nettype wire

/* hw/rtl/ptl_in_if.sv */
// Item channel of the packed trie lookup unit.
`default_nettype none

interface ptl_in_if
    import ptl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  write_address;
    logic [BYTE_W-1:0] write_byte;
    logic [BYTE_W-1:0] probe_char;

    modport source (
        output valid, mode, write_address, write_byte, probe_char,
        input  ready
    );

    modport sink (
        input  valid, mode, write_address, write_byte, probe_char,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/ptl_out_if.sv */
// Result channel of the packed trie lookup unit.
`default_nettype none

interface ptl_out_if
    import ptl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              matched;
    logic [BYTE_W-1:0] result_char;
    logic [POS_W-1:0]  node_position;

    modport source (
        output valid, matched, result_char, node_position,
        input  ready
    );

    modport sink (
        input  valid, matched, result_char, node_position,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/packed_trie_lookup_unit.sv */
// Top level of the packed trie lookup unit.
//
// Item beats arrive on in_ch (valid/ready); each item is a trie byte write
// (mode 0), a rewind to the root (mode 1) or a one-character step (mode 2).
// Every item yields exactly one result beat on out_ch: matched, the result
// byte of the current node (zero after a failed step) and its position.
// trie_length is written through cfg_write_en/cfg_write_data; the user must
// write it only while idle, as the block itself does not enforce this. One item
// is worked at a time by a sequencer over a single-port trie memory with a
// registered read. Writes, rewinds and steps after a failure go straight from
// decode to the result read. A step reads the two count bytes of the current
// node and fails at a leaf; it then reads the digit byte of each child in turn,
// failing when that child does not fit in memory, taking it on a match, and
// else reading its count to skip its subtree or to fail when the sibling scan
// runs out. The next item is accepted in the cycle after the result is loaded,
// even while that result waits; a stalled receiver holds the result register
// and the following item then waits in its last cycle until the slot frees.
// Reset returns to the root, clears the failure flag and trie_length, and
// drops any pending result; trie memory contents are not cleared.
`default_nettype none

module packed_trie_lookup_unit
    import ptl_pkg::*;
#(
    parameter int TRIE_BYTES = 16384
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [LEN_W-1:0] cfg_write_data,
    ptl_in_if.sink                in_ch,
    ptl_out_if.source             out_ch
);

    ptl_cmd_t    cmd;
    ptl_status_t status;
    logic        in_ready;

    assign in_ch.ready = in_ready;

    ptl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptl_datapath #(
        .TRIE_BYTES (TRIE_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_mode           (in_ch.mode),
        .in_write_address  (in_ch.write_address),
        .in_write_byte     (in_ch.write_byte),
        .in_probe_char     (in_ch.probe_char),
        .out_ready         (out_ch.ready),
        .out_valid         (out_ch.valid),
        .out_matched       (out_ch.matched),
        .out_result_char   (out_ch.result_char),
        .out_node_position (out_ch.node_position),
        .cmd               (cmd),
        .status            (status)
    );

    // A result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("result register overwritten while stalled");

    // Only one item is in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in work");

    // A trie write happens only right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_write |-> $past(in_ch.valid && in_ready))
        else $error("trie write without a fresh item");

    // A step cannot both find a child and fail
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take_child && cmd.set_fail))
        else $error("step matched and failed together");

endmodule

`default_nettype wire

/* hw/rtl/ptl_ctrl.sv */
// Sequencer of the packed trie lookup unit.
`default_nettype none

module ptl_ctrl
    import ptl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire ptl_status_t status,
    output ptl_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_ROOT0    = 4'd2;
    localparam logic [3:0] S_ROOT1    = 4'd3;
    localparam logic [3:0] S_ROOT2    = 4'd4;
    localparam logic [3:0] S_CHILD0   = 4'd5;
    localparam logic [3:0] S_CHILD1   = 4'd6;
    localparam logic [3:0] S_CHILD2   = 4'd7;
    localparam logic [3:0] S_RES_ADDR = 4'd8;
    localparam logic [3:0] S_RES_DATA = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decode state into datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_SCAN;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RES_ADDR;
                case (status.mode)
                    MODE_WRITE:  cmd.mem_write = 1'b1;
                    MODE_REWIND: cmd.rewind    = 1'b1;
                    MODE_STEP:
                    begin
                        if (!status.failed)
                        begin
                            cmd.start_scan = 1'b1;
                            state_next     = S_ROOT0;
                        end
                    end
                    default: state_next = S_RES_ADDR;
                endcase
            end
            S_ROOT0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SCAN;
                state_next = S_ROOT1;
            end
            S_ROOT1:
            begin
                cmd.load_hi = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_SCAN1;
                state_next  = S_ROOT2;
            end
            S_ROOT2:
            begin
                cmd.load_total = 1'b1;
                if (status.total_zero)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_RES_ADDR;
                end
                else
                    state_next = S_CHILD0;
            end
            S_CHILD0:
            begin
                if (status.child_oob)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_RES_ADDR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CHILD;
                    state_next = S_CHILD1;
                end
            end
            S_CHILD1:
            begin
                if (status.digit_hit)
                begin
                    cmd.take_child = 1'b1;
                    state_next     = S_RES_ADDR;
                end
                else
                begin
                    cmd.load_hi = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_CHILD1;
                    state_next  = S_CHILD2;
                end
            end
            S_CHILD2:
            begin
                if (status.scan_end)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_RES_ADDR;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHILD0;
                end
            end
            S_RES_ADDR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_RESULT;
                state_next = S_RES_DATA;
            end
            S_RES_DATA:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/ptl_datapath.sv */
// Trie memory, scan registers and result register of the packed trie lookup unit.
`default_nettype none

module ptl_datapath
    import ptl_pkg::*;
#(
    parameter int TRIE_BYTES = 16384
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [LEN_W-1:0]  cfg_write_data,
    input  wire logic [MODE_W-1:0] in_mode,
    input  wire logic [POS_W-1:0]  in_write_address,
    input  wire logic [BYTE_W-1:0] in_write_byte,
    input  wire logic [BYTE_W-1:0] in_probe_char,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   out_matched,
    output logic [BYTE_W-1:0]      out_result_char,
    output logic [POS_W-1:0]       out_node_position,
    input  wire ptl_cmd_t          cmd,
    output ptl_status_t            status
);

    localparam int AW = (TRIE_BYTES > 1) ? $clog2(TRIE_BYTES) : 1;
    localparam logic [SUM_W-1:0] BYTES_EXT = SUM_W'(TRIE_BYTES);

    logic [BYTE_W-1:0] mem [TRIE_BYTES];

    logic [LEN_W-1:0]   trie_length_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [POS_W-1:0]   addr_reg;
    logic [BYTE_W-1:0]  wbyte_reg;
    logic [BYTE_W-1:0]  char_reg;
    logic [POS_W-1:0]   cur_pos_reg;
    logic               failed_reg;
    logic               hit_reg;
    logic [POS_W-1:0]   scan_pos_reg;
    logic [COUNT_W-1:0] skipped_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [3:0]         hi_reg;
    logic [BYTE_W-1:0]  rdata_reg;
    logic               out_valid_reg;
    logic               out_matched_reg;
    logic [BYTE_W-1:0]  out_char_reg;
    logic [POS_W-1:0]   out_pos_reg;

    logic [SUM_W-1:0]   scan_ext;
    logic [SUM_W-1:0]   rd_addr_full;
    logic [AW-1:0]      rd_addr;
    logic               wr_in_range;
    logic [COUNT_W-1:0] count_now;
    logic [SUM_W-1:0]   sub_plus1;
    logic [SUM_W-1:0]   skip_sum;
    logic [SUM_W-1:0]   step3;
    logic [SUM_W-1:0]   next_pos;
    logic [SUM_W-1:0]   limit;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trie_length_reg <= '0;
        else if (cfg_write_en)
            trie_length_reg <= cfg_write_data;
    end

    // Address and scan arithmetic
    always_comb
    begin
        scan_ext  = SUM_W'(scan_pos_reg);
        count_now = {hi_reg, rdata_reg};
        sub_plus1 = SUM_W'(count_now) + SUM_W'(1);
        skip_sum  = SUM_W'(skipped_reg) + sub_plus1;
        step3     = (sub_plus1 << 1) + sub_plus1;
        next_pos  = scan_ext + step3;
        limit     = (SUM_W'(trie_length_reg) > BYTES_EXT) ? BYTES_EXT
                                                           : SUM_W'(trie_length_reg);
        case (cmd.rd_sel)
            RD_SCAN:   rd_addr_full = scan_ext;
            RD_SCAN1:  rd_addr_full = scan_ext + SUM_W'(1);
            RD_CHILD:  rd_addr_full = scan_ext + SUM_W'(3);
            RD_CHILD1: rd_addr_full = scan_ext + SUM_W'(4);
            RD_RESULT: rd_addr_full = SUM_W'(cur_pos_reg) + SUM_W'(2);
            default:   rd_addr_full = SUM_W'(cur_pos_reg);
        endcase
        rd_addr     = rd_addr_full[AW-1:0];
        wr_in_range = SUM_W'(addr_reg) < BYTES_EXT;
    end

    // Trie memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && wr_in_range)
            mem[addr_reg[AW-1:0]] <= wbyte_reg;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Item payload and scan working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg  <= in_mode;
            addr_reg  <= in_write_address;
            wbyte_reg <= in_write_byte;
            char_reg  <= in_probe_char;
        end
        if (cmd.start_scan)
        begin
            scan_pos_reg <= cur_pos_reg;
            skipped_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            scan_pos_reg <= next_pos[POS_W-1:0];
            skipped_reg  <= skip_sum[COUNT_W-1:0];
        end
        if (cmd.load_hi)
            hi_reg <= rdata_reg[3:0];
        if (cmd.load_total)
            total_reg <= count_now;
    end

    // Lookup state: current node, sticky failure, match of this item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= '0;
            failed_reg  <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
                hit_reg <= 1'b0;
            if (cmd.rewind)
            begin
                cur_pos_reg <= '0;
                failed_reg  <= 1'b0;
            end
            if (cmd.set_fail)
                failed_reg <= 1'b1;
            if (cmd.take_child)
            begin
                cur_pos_reg <= scan_pos_reg + POS_W'(3);
                hit_reg     <= 1'b1;
            end
        end
    end

    // Result register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_matched_reg <= hit_reg;
            out_char_reg    <= failed_reg ? '0 : rdata_reg;
            out_pos_reg     <= cur_pos_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_matched       = out_matched_reg;
    assign out_result_char   = out_char_reg;
    assign out_node_position = out_pos_reg;

    // Status back to the sequencer
    always_comb
    begin
        status            = '0;
        status.mode       = mode_reg;
        status.failed     = failed_reg;
        status.total_zero = (count_now == '0);
        status.child_oob  = (scan_ext + SUM_W'(6)) > BYTES_EXT;
        status.digit_hit  = (DIGIT_BASE + {4'b0, rdata_reg[7:4]}) == char_reg;
        status.scan_end   = (skip_sum >= SUM_W'(total_reg))
                          || ((next_pos + SUM_W'(3)) >= limit);
        status.out_free   = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

/* dv/packed_trie_lookup_unit_test.sv */
// Self-checking testbench for the packed trie lookup unit: directed tries plus random lookups.
`timescale 1ns / 1ps

module packed_trie_lookup_unit_test
    import ptl_pkg::*;
;

    localparam int TRIE_SPAN    = 16384;
    localparam int PREFIX_BYTES = 96;
    localparam int MAX_NODES    = 32;
    localparam int PHASES       = 8;
    localparam int LOOKUPS      = 120;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES  = 64;
    localparam int STALL_LIMIT  = 2000;

    // Unused mode code: reported like a write that changes nothing
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic              matched;
        logic [BYTE_W-1:0] result_char;
        logic [POS_W-1:0]  node_position;
    } lookup_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [LEN_W-1:0] cfg_write_data;

    ptl_in_if  in_ch ();
    ptl_out_if out_ch ();

    packed_trie_lookup_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch)
    );

    // Mirror of the trie memory and lookup state
    logic [BYTE_W-1:0] trie_image [TRIE_SPAN] = '{default: '0};
    bit                byte_loaded [TRIE_SPAN] = '{default: 1'b0};
    int                cur_node    = 0;
    bit                lookup_dead = 1'b0;
    int                trie_len    = 0;

    lookup_result_t awaited_lookups [$];
    int             error_count = 0;
    int             burst_left  = 0;
    bit             steady_feed = 1'b0;
    int             idle_cycles = 0;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int mem_rd(input int addr);
        if (addr >= TRIE_SPAN)
            return 0;
        return int'(trie_image[addr]);
    endfunction

    function automatic int count_rd(input int addr);
        return ((mem_rd(addr) & 'hf) << 8) | mem_rd(addr + 1);
    endfunction

    // All three bytes of the node at addr have been loaded
    function automatic bit node_known(input int addr);
        return (addr + 2 < TRIE_SPAN) && byte_loaded[addr] && byte_loaded[addr + 1]
            && byte_loaded[addr + 2];
    endfunction

    // Scan the children of the current node for ch; flag any read of unloaded memory
    function automatic void scan_children(input int ch, output bit hit, output int landing,
                                          output bit clean);
        int limit;
        int pos;
        int total;
        int skipped;
        int child;
        int sub;
        limit = (trie_len > TRIE_SPAN) ? TRIE_SPAN : trie_len;
        pos = cur_node;
        total = count_rd(pos);
        skipped = 0;
        hit = 1'b0;
        landing = pos;
        clean = node_known(pos);
        if (total == 0)
            return;
        forever
        begin
            child = pos + 3;
            if (child + 3 > TRIE_SPAN)
                return;
            clean &= node_known(child);
            if (int'(DIGIT_BASE) + ((mem_rd(child) >> 4) & 'hf) == ch)
            begin
                hit = 1'b1;
                landing = child;
                return;
            end
            sub = count_rd(child);
            if (skipped + sub + 1 >= total)
                return;
            if (pos + 3 * (sub + 2) >= limit)
                return;
            pos += 3 * (sub + 1);
            skipped += sub + 1;
        end
    endfunction

    // Apply one accepted item and queue the result beat it should produce
    function automatic void predict_lookup(input logic [MODE_W-1:0] mode,
                                           input logic [POS_W-1:0] addr,
                                           input logic [BYTE_W-1:0] data,
                                           input logic [BYTE_W-1:0] ch);
        lookup_result_t want;
        bit hit;
        bit clean;
        int landing;
        hit = 1'b0;
        case (mode)
            MODE_WRITE:
            begin
                trie_image[addr] = data;
                byte_loaded[addr] = 1'b1;
            end
            MODE_REWIND:
            begin
                cur_node = 0;
                lookup_dead = 1'b0;
            end
            MODE_STEP:
            begin
                if (!lookup_dead)
                begin
                    scan_children(int'(ch), hit, landing, clean);
                    if (hit)
                        cur_node = landing;
                    else
                        lookup_dead = 1'b1;
                end
            end
            default: ;
        endcase
        want.matched = hit;
        want.result_char = lookup_dead ? '0 : BYTE_W'(mem_rd(cur_node + 2));
        want.node_position = POS_W'(cur_node);
        awaited_lookups.push_back(want);
    endfunction

    // Digit character of the child reached after a number of sibling hops
    function automatic logic [BYTE_W-1:0] child_char(input int hops);
        int child;
        int total;
        int skipped;
        int sub;
        total = count_rd(cur_node);
        child = cur_node + 3;
        skipped = 0;
        for (int i = 0; i < hops; i++)
        begin
            sub = count_rd(child);
            if (skipped + sub + 1 >= total)
                break;
            skipped += sub + 1;
            child += 3 * (sub + 1);
        end
        return BYTE_W'(int'(DIGIT_BASE) + ((mem_rd(child) >> 4) & 'hf));
    endfunction

    // Send one item beat in bursts, with random gaps unless steady_feed is set, then predict it
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] addr,
                             input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!steady_feed)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= mode;
        in_ch.write_address <= addr;
        in_ch.write_byte    <= data;
        in_ch.probe_char    <= ch;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_lookup(mode, addr, data, ch);
    endtask

    task automatic send_write(input logic [POS_W-1:0] addr, input logic [BYTE_W-1:0] data);
        send_item(MODE_WRITE, addr, data, BYTE_W'($urandom));
    endtask

    task automatic send_rewind();
        send_item(MODE_REWIND, POS_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic send_step(input logic [BYTE_W-1:0] ch);
        send_item(MODE_STEP, POS_W'($urandom), BYTE_W'($urandom), ch);
    endtask

    // Step only where every byte read has been loaded; rewind otherwise
    task automatic guarded_step(input logic [BYTE_W-1:0] ch);
        bit hit;
        bit clean;
        int landing;
        if (!lookup_dead)
        begin
            scan_children(int'(ch), hit, landing, clean);
            if (!clean)
            begin
                send_rewind();
                return;
            end
        end
        send_step(ch);
    endtask

    // Drop valid and wait until every result beat is back and the unit is idle
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (awaited_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_trie_length(input logic [LEN_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        trie_len = int'(value);
    endtask

    // Load the low memory so later steps never touch unwritten bytes
    task automatic test_memory_fill();
        send_write(POS_W'(2), BYTE_W'($urandom));
        for (int a = 0; a < PREFIX_BYTES; a++)
        begin
            if (a != 2)
                send_write(POS_W'(a), BYTE_W'($urandom));
        end
    endtask

    // Hand-built trie: first child, deeper match, leaf, sticky failure, skip, scan ends
    task automatic test_small_trie();
        logic [BYTE_W-1:0] image [12];
        image = '{8'h00, 8'h03, 8'hff,    // root, three descendants
                  8'h10, 8'h01, 8'h61,    // digit 1, one descendant
                  8'h20, 8'h00, 8'h62,    // digit 2, leaf
                  8'h50, 8'h00, 8'h00};   // digit 5, leaf
        drain();
        set_trie_length(LEN_W'(12));
        for (int a = 0; a < 12; a++)
            send_write(POS_W'(a), image[a]);
        send_rewind();
        send_step(8'h31);
        send_step(8'h32);
        send_step(8'h33);
        send_step(8'h00);
        send_item(MODE_NONE, POS_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        send_rewind();
        send_step(8'h35);
        send_rewind();
        send_step(8'h39);
        // Shrink the length so the second sibling lands on the bound
        drain();
        set_trie_length(LEN_W'(9));
        send_rewind();
        send_step(8'h35);
    endtask

    // Walk to the top of memory where the next child no longer fits
    task automatic test_memory_top();
        drain();
        set_trie_length(LEN_W'(16384));
        send_write(POS_W'(0), 8'h0f);
        send_write(POS_W'(1), 8'hff);
        send_write(POS_W'(2), BYTE_W'($urandom));
        send_write(POS_W'(3), 8'h1f);
        send_write(POS_W'(4), 8'hfd);
        send_write(POS_W'(5), BYTE_W'($urandom));
        send_write(POS_W'(12285), 8'h27);
        send_write(POS_W'(12286), 8'hd0);
        send_write(POS_W'(12287), BYTE_W'($urandom));
        send_write(POS_W'(12288), 8'h35);
        send_write(POS_W'(12289), 8'h54);
        send_write(POS_W'(12290), BYTE_W'($urandom));
        send_write(POS_W'(16383), BYTE_W'($urandom));
        send_rewind();
        send_step(8'h32);
        send_step(8'h34);
        send_rewind();
        send_step(8'hff);
        // Lengths above the memory size act as the memory size
        drain();
        set_trie_length(LEN_W'(32767));
        send_rewind();
        send_step(8'h32);
        send_step(8'h34);
    endtask

    // Build a random well-formed trie at address 0 from a preorder depth list
    task automatic load_random_trie(input int nodes);
        int depth [MAX_NODES];
        int desc [MAX_NODES];
        int top;
        logic [3:0] digit;
        depth[0] = 0;
        for (int i = 1; i < nodes; i++)
        begin
            top = depth[i - 1] + 1;
            if (top > 5)
                top = 5;
            depth[i] = $urandom_range(1, top);
        end
        for (int i = 0; i < nodes; i++)
        begin
            desc[i] = 0;
            for (int j = i + 1; j < nodes && depth[j] > depth[i]; j++)
                desc[i]++;
        end
        for (int i = 0; i < nodes; i++)
        begin
            digit = 4'($urandom_range(0, 15));
            send_write(POS_W'(3 * i), {digit, desc[i][11:8]});
            send_write(POS_W'(3 * i + 1), desc[i][7:0]);
            send_write(POS_W'(3 * i + 2), BYTE_W'($urandom));
        end
    endtask

    // Random tries and lookup sequences under several trie lengths
    task automatic test_random_lookups();
        int nodes;
        int pick;
        logic [LEN_W-1:0] length;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            nodes = $urandom_range(2, MAX_NODES);
            case (phase)
                0: length = '0;
                1: length = LEN_W'(32767);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: length = LEN_W'(3 * nodes);
                        1: length = LEN_W'(16384);
                        2: length = LEN_W'($urandom_range(0, 3 * nodes + 6));
                        default: length = LEN_W'($urandom_range(0, 32767));
                    endcase
                end
            endcase
            drain();
            set_trie_length(length);
            steady_feed = ($urandom_range(0, 3) == 0);
            load_random_trie(nodes);
            send_rewind();
            for (int k = 0; k < LOOKUPS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (lookup_dead && pick < 60)
                    send_rewind();
                else if (pick < 12)
                    send_rewind();
                else if (pick < 72)
                    guarded_step(child_char($urandom_range(0, 3)));
                else if (pick < 84)
                    guarded_step(BYTE_W'($urandom_range(0, 255)));
                else if (pick < 90)
                    guarded_step(BYTE_W'(int'(DIGIT_BASE) + $urandom_range(0, 15)));
                else if (pick < 94)
                    send_item(MODE_NONE, POS_W'($urandom), BYTE_W'($urandom),
                              BYTE_W'($urandom));
                else if (pick < 97)
                    send_write(POS_W'($urandom), BYTE_W'($urandom));
                else
                    send_write(POS_W'($urandom_range(0, 3 * nodes - 1)), BYTE_W'($urandom));
            end
        end
        steady_feed = 1'b0;
    endtask

    // Reset, run each test in turn, then report
    initial
    begin
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        in_ch.valid         = 1'b0;
        in_ch.mode          = MODE_WRITE;
        in_ch.write_address = '0;
        in_ch.write_byte    = '0;
        in_ch.probe_char    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_memory_fill();
        test_small_trie();
        test_memory_top();
        test_random_lookups();
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_lookups.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived", $time, awaited_lookups.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: hold ready on a pattern that rotates among four kinds
    initial
    begin
        int pattern_cycle;
        int stall_left;
        pattern_cycle = 0;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            pattern_cycle++;
            case ((pattern_cycle / 256) % 4)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ((pattern_cycle % 7) < 4);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_lookups.size() == 0)
            begin
                $display("%0t: unexpected result beat: matched %0d result 0x%02h position %0d",
                         $time, out_ch.matched, out_ch.result_char, out_ch.node_position);
                error_count++;
            end
            else
            begin
                want = awaited_lookups.pop_front();
                if (out_ch.matched !== want.matched)
                begin
                    $display("%0t: matched: expected %0d, actual %0d",
                             $time, want.matched, out_ch.matched);
                    error_count++;
                end
                if (out_ch.result_char !== want.result_char)
                begin
                    $display("%0t: result_char: expected 0x%02h, actual 0x%02h",
                             $time, want.result_char, out_ch.result_char);
                    error_count++;
                end
                if (out_ch.node_position !== want.node_position)
                begin
                    $display("%0t: node_position: expected %0d, actual %0d",
                             $time, want.node_position, out_ch.node_position);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
